FILE: hw/rtl/tsw_pkg.sv
// Shared types, constants and the microcode store for the tube saturation waveshaper.
// No dependencies; imported by tube_saturation_waveshaper.

package tsw_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_HALF,
    OP_MULQ,
    OP_MULI,
    OP_DIVQ,
    OP_DIVI,
    OP_ROOT
  } op_t;

  // Operand sources
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_TWO, SRC_K1200, SRC_K26000, SRC_DL, SRC_SR, SRC_SR10,
    SRC_BDEN, SRC_T0, SRC_T1, SRC_RECIP, SRC_BEND, SRC_R2, SRC_S1, SRC_KCV,
    SRC_SQV, SRC_DSQ, SRC_PSLOPE, SRC_NSLOPE, SRC_NOFF, SRC_NBIAS, SRC_NORM, SRC_HP,
    SRC_X, SRC_XS, SRC_T0S, SRC_SLOPE_SEL, SRC_OFF_SEL, SRC_BIAS_SEL, SRC_LSH, SRC_LOUT
  } src_t;

  // Write-back destinations
  typedef enum logic [4:0] {
    DST_T0, DST_T1, DST_RECIP, DST_BEND, DST_R2, DST_S1, DST_KCV, DST_SQV, DST_DSQ,
    DST_PSLOPE, DST_PBIAS, DST_POFF, DST_HP, DST_NBIAS, DST_NSLOPE, DST_NOFF, DST_NORM
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } uop_t;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_SAMPLE = 6'd39;
  localparam logic [PC_W-1:0] PC_DERIVE_END = 6'd38;
  localparam logic [PC_W-1:0] PC_LAST = 6'd48;

  localparam logic signed [47:0] QLIM = 48'sh7FFF_FFFF_FFFF;

  localparam logic [9:0] DRIVE_MIN = 10'd10;
  localparam logic [9:0] DRIVE_MAX = 10'd1000;
  localparam logic signed [10:0] BLEND_LIM = 11'sd1000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRATE = 2'd2;

  // Microcode: coefficient derivation, then per-sample shaping and filtering
  function automatic uop_t uop(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = '{OP_DIVQ, SRC_K1200,     SRC_DL,       DST_RECIP};
      6'd1:  u = '{OP_MULI, SRC_RECIP,     SRC_K26000,   DST_T0};
      6'd2:  u = '{OP_DIVI, SRC_T0,        SRC_BDEN,     DST_BEND};
      6'd3:  u = '{OP_MULQ, SRC_RECIP,     SRC_RECIP,    DST_R2};
      6'd4:  u = '{OP_ADD,  SRC_R2,        SRC_R2,       DST_T0};
      6'd5:  u = '{OP_SUB,  SRC_T0,        SRC_ONE,      DST_T0};
      6'd6:  u = '{OP_ROOT, SRC_T0,        SRC_ZERO,     DST_S1};
      6'd7:  u = '{OP_ADD,  SRC_S1,        SRC_ONE,      DST_PSLOPE};
      6'd8:  u = '{OP_SUB,  SRC_TWO,       SRC_PSLOPE,   DST_T0};
      6'd9:  u = '{OP_HALF, SRC_T0,        SRC_ZERO,     DST_PBIAS};
      6'd10: u = '{OP_SUB,  SRC_R2,        SRC_PSLOPE,   DST_T0};
      6'd11: u = '{OP_ADD,  SRC_T0,        SRC_ONE,      DST_T0};
      6'd12: u = '{OP_HALF, SRC_T0,        SRC_ZERO,     DST_POFF};
      6'd13: u = '{OP_ADD,  SRC_S1,        SRC_S1,       DST_T0};
      6'd14: u = '{OP_ADD,  SRC_R2,        SRC_R2,       DST_T1};
      6'd15: u = '{OP_SUB,  SRC_T0,        SRC_T1,       DST_T0};
      6'd16: u = '{OP_ROOT, SRC_T0,        SRC_ZERO,     DST_T0};
      6'd17: u = '{OP_DIVQ, SRC_PSLOPE,    SRC_T0,       DST_KCV};
      6'd18: u = '{OP_DIVQ, SRC_SR,        SRC_SR10,     DST_HP};
      6'd19: u = '{OP_MULQ, SRC_KCV,       SRC_KCV,      DST_T0};
      6'd20: u = '{OP_ADD,  SRC_T0,        SRC_ONE,      DST_SQV};
      6'd21: u = '{OP_ROOT, SRC_SQV,       SRC_ZERO,     DST_DSQ};
      6'd22: u = '{OP_DIVQ, SRC_BEND,      SRC_DSQ,      DST_T0};
      6'd23: u = '{OP_SUB,  SRC_ZERO,      SRC_T0,       DST_NBIAS};
      6'd24: u = '{OP_ADD,  SRC_KCV,       SRC_KCV,      DST_T0};
      6'd25: u = '{OP_MULQ, SRC_T0,        SRC_BEND,     DST_T0};
      6'd26: u = '{OP_DIVQ, SRC_T0,        SRC_DSQ,      DST_NSLOPE};
      6'd27: u = '{OP_DIVQ, SRC_BEND,      SRC_SQV,      DST_T0};
      6'd28: u = '{OP_MULQ, SRC_BEND,      SRC_T0,       DST_NOFF};
      6'd29: u = '{OP_ADD,  SRC_NSLOPE,    SRC_NSLOPE,   DST_T0};
      6'd30: u = '{OP_ADD,  SRC_NOFF,      SRC_NOFF,     DST_T1};
      6'd31: u = '{OP_ADD,  SRC_T1,        SRC_T1,       DST_T1};
      6'd32: u = '{OP_ADD,  SRC_T0,        SRC_T1,       DST_T0};
      6'd33: u = '{OP_SUB,  SRC_T0,        SRC_ONE,      DST_T0};
      6'd34: u = '{OP_ROOT, SRC_T0,        SRC_ZERO,     DST_T0};
      6'd35: u = '{OP_ADD,  SRC_NBIAS,     SRC_NBIAS,    DST_T1};
      6'd36: u = '{OP_ADD,  SRC_T1,        SRC_T0,       DST_T0};
      6'd37: u = '{OP_ADD,  SRC_T0,        SRC_ONE,      DST_T0};
      6'd38: u = '{OP_DIVQ, SRC_TWO,       SRC_T0,       DST_NORM};
      6'd39: u = '{OP_ADD,  SRC_SLOPE_SEL, SRC_XS,       DST_T0};
      6'd40: u = '{OP_MULQ, SRC_X,         SRC_T0,       DST_T0};
      6'd41: u = '{OP_ADD,  SRC_OFF_SEL,   SRC_T0S,      DST_T0};
      6'd42: u = '{OP_ROOT, SRC_T0,        SRC_ZERO,     DST_T0};
      6'd43: u = '{OP_ADD,  SRC_T0,        SRC_BIAS_SEL, DST_T0};
      6'd44: u = '{OP_MULQ, SRC_T0,        SRC_NORM,     DST_T0};
      6'd45: u = '{OP_ADD,  SRC_ZERO,      SRC_T0S,      DST_T1};
      6'd46: u = '{OP_SUB,  SRC_T1,        SRC_LSH,      DST_T0};
      6'd47: u = '{OP_ADD,  SRC_T0,        SRC_LOUT,     DST_T0};
      6'd48: u = '{OP_MULQ, SRC_HP,        SRC_T0,       DST_T0};
      default: u = '{OP_ADD, SRC_ZERO,     SRC_ZERO,     DST_T0};
    endcase
    return u;
  endfunction

endpackage

FILE: hw/rtl/tube_saturation_waveshaper.sv
// Tube saturation waveshaper: square-root transfer curve, DC blocker and output clamp.
// Depends on tsw_pkg for the sequencer types, constants and microcode.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tlast carry one input word: a signed sample in
//   tdata and the end-of-block mark in tlast. m_* carry one result word per input
//   word, the processed sample and the copied mark. cfg_valid/cfg_index/cfg_data
//   write drive (0), blend (1) and sample rate (2); cfg_ready is always high.
//   A microcode sequencer drives one adder and three multi-cycle units
//   (four-step partial-product multiplier, restoring divider of 48+COEF_FRAC_BITS
//   steps, bit-serial square root of (49+COEF_FRAC_BITS)/2 steps).
//   Per sample the program runs one square root and three multiplies. The first
//   sample after reset or a register write first recomputes the coefficients:
//   eight divides, four square roots and five multiplies.
//   With drive below 10 a sample passes through unchanged.
//   s_tready is high only while the sequencer is idle. The result sits in an
//   output register; the next word is accepted while it waits, and a stalled
//   receiver holds the sequencer at its final step. Reset clears the filter
//   history and marks the coefficients for recomputation.

module tube_saturation_waveshaper
  import tsw_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] in_sample
  input  logic                                   s_tlast,   // end_of_block
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // [SAMPLE_BITS-1:0] out_sample
  output logic                                   m_tlast,   // end_of_block_res
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_data
);

  localparam int DATA_W = ((SAMPLE_BITS+7)/8)*8;
  localparam int SH = COEF_FRAC_BITS - (SAMPLE_BITS - 1);
  localparam int SHL = (SH >= 0) ? SH : 0;
  localparam int SHR = (SH < 0) ? -SH : 0;
  localparam logic signed [47:0] QONE = 48'sd1 <<< COEF_FRAC_BITS;
  localparam logic signed [47:0] QTWO = QONE <<< 1;
  localparam logic [47:0] EPS = 48'((64'd1 << COEF_FRAC_BITS) / 64'd1000000000);
  localparam int NW = 48 + COEF_FRAC_BITS;
  localparam int DIV_CW = $clog2(NW);
  localparam int NP = (48 + COEF_FRAC_BITS + 1) / 2;
  localparam int RADW = 2 * NP;
  localparam int SQ_CW = $clog2(NP);
  localparam logic [63:0] TOP = 64'd1 << (SAMPLE_BITS - 1);

  // ---------------------------------------------------------------- helpers
  function automatic logic [47:0] mag(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [47:0] from_mag(input logic neg, input logic [95:0] m);
    logic [47:0] mm;
    mm = (m > 96'(QLIM)) ? 48'(QLIM) : m[47:0];
    return neg ? -$signed(mm) : $signed(mm);
  endfunction

  function automatic logic signed [47:0] qadd(input logic signed [47:0] a,
                                              input logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s > 49'(QLIM)) return QLIM;
    if (s < -49'(QLIM)) return -QLIM;
    return 48'(s);
  endfunction

  function automatic logic signed [47:0] small_zero(input logic signed [47:0] v);
    return (mag(v) <= EPS) ? 48'sd0 : v;
  endfunction

  // ---------------------------------------------------------------- registers
  state_t state, state_next;
  logic [PC_W-1:0] pc;
  logic stale;
  logic [9:0] drive;
  logic signed [10:0] blend;
  logic [17:0] srate;
  logic nsamp, eob;
  logic [SAMPLE_BITS-1:0] res;
  logic signed [47:0] t0, t1, recip, bend, r2, s1, kcv, sqv, dsq;
  logic signed [47:0] pslope, pbias, poff, nslope, noff, nbias, norm, hp, lsh, lout, x;

  uop_t u;
  logic start, wr_en, simple_op, unit_done;
  logic signed [47:0] opa, opb, alu_val, unit_val, wr_val;

  assign u = uop(pc);
  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- register-derived operands
  logic [47:0] dl_val;
  logic signed [10:0] blc;
  logic signed [12:0] bdiff;
  logic [15:0] bden;

  always_comb begin
    dl_val = (drive > DRIVE_MAX) ? 48'(DRIVE_MAX) : 48'(drive);
    if (blend > BLEND_LIM) blc = BLEND_LIM;
    else if (blend < -BLEND_LIM) blc = -BLEND_LIM;
    else blc = blend;
    bdiff = 13'sd1050 - 13'(blc);
    bden = 16'(bdiff[11:0]) * 16'd11;
  end

  // operand select
  function automatic logic signed [47:0] pick(input src_t s);
    logic signed [47:0] v;
    unique case (s)
      SRC_ZERO:      v = 48'sd0;
      SRC_ONE:       v = QONE;
      SRC_TWO:       v = QTWO;
      SRC_K1200:     v = 48'sd1200;
      SRC_K26000:    v = 48'sd26000;
      SRC_DL:        v = $signed(dl_val);
      SRC_SR:        v = $signed(48'(srate));
      SRC_SR10:      v = $signed(48'(srate) + 48'd10);
      SRC_BDEN:      v = $signed(48'(bden));
      SRC_T0:        v = t0;
      SRC_T1:        v = t1;
      SRC_RECIP:     v = recip;
      SRC_BEND:      v = bend;
      SRC_R2:        v = r2;
      SRC_S1:        v = s1;
      SRC_KCV:       v = kcv;
      SRC_SQV:       v = sqv;
      SRC_DSQ:       v = dsq;
      SRC_PSLOPE:    v = pslope;
      SRC_NSLOPE:    v = nslope;
      SRC_NOFF:      v = noff;
      SRC_NBIAS:     v = nbias;
      SRC_NORM:      v = norm;
      SRC_HP:        v = hp;
      SRC_X:         v = x;
      SRC_XS:        v = nsamp ? x : -x;
      SRC_T0S:       v = nsamp ? -t0 : t0;
      SRC_SLOPE_SEL: v = nsamp ? nslope : pslope;
      SRC_OFF_SEL:   v = nsamp ? noff : poff;
      SRC_BIAS_SEL:  v = nsamp ? nbias : pbias;
      SRC_LSH:       v = lsh;
      SRC_LOUT:      v = lout;
      default:       v = 48'sd0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(u.a);
    opb = pick(u.b);
  end

  // combinational adder path
  always_comb begin
    simple_op = (u.op == OP_ADD) || (u.op == OP_SUB) || (u.op == OP_HALF);
    unique case (u.op)
      OP_SUB:  alu_val = qadd(opa, -opb);
      OP_HALF: alu_val = from_mag(opa[47], 96'(mag(opa) >> 1));
      default: alu_val = qadd(opa, opb);
    endcase
  end

  // ---------------------------------------------------------------- multiplier
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_acc;
  logic [1:0] mul_cnt;
  logic mul_busy, mul_done, mul_neg, mul_q;
  logic [47:0] mul_pp;
  logic [95:0] mul_sh;

  always_comb begin
    mul_pp = (mul_cnt[1] ? 48'(mul_a[47:24]) : 48'(mul_a[23:0]))
           * (mul_cnt[0] ? 48'(mul_b[47:24]) : 48'(mul_b[23:0]));
    mul_sh = mul_q ? (mul_acc >> COEF_FRAC_BITS) : mul_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else if (start && (u.op == OP_MULQ || u.op == OP_MULI)) begin
      mul_busy <= 1'b1;
      mul_done <= 1'b0;
    end else if (mul_busy && mul_cnt == 2'd3) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b1;
    end
  end

  // accumulate one 24x24 partial product a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mul_a <= mag(opa);
      mul_b <= mag(opb);
      mul_neg <= opa[47] ^ opb[47];
      mul_q <= (u.op == OP_MULQ);
      mul_acc <= '0;
      mul_cnt <= '0;
    end else if (mul_busy) begin
      unique case (mul_cnt)
        2'd0:    mul_acc <= mul_acc + 96'(mul_pp);
        2'd3:    mul_acc <= mul_acc + (96'(mul_pp) << 48);
        default: mul_acc <= mul_acc + (96'(mul_pp) << 24);
      endcase
      mul_cnt <= mul_cnt + 2'd1;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [NW-1:0] div_num, div_quo;
  logic [47:0] div_den, div_rem;
  logic [DIV_CW-1:0] div_cnt;
  logic div_busy, div_done, div_neg, div_zero;
  logic [48:0] div_rsh;

  assign div_rsh = {div_rem, div_num[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else if (start && (u.op == OP_DIVQ || u.op == OP_DIVI)) begin
      div_busy <= 1'b1;
      div_done <= 1'b0;
    end else if (div_busy && div_cnt == DIV_CW'(NW - 1)) begin
      div_busy <= 1'b0;
      div_done <= 1'b1;
    end
  end

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      div_num <= (u.op == OP_DIVQ) ? (NW'(mag(opa)) << COEF_FRAC_BITS) : NW'(mag(opa));
      div_den <= mag(opb);
      div_neg <= opa[47] ^ opb[47];
      div_zero <= (opa == 48'sd0);
      div_rem <= '0;
      div_quo <= '0;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_num <= div_num << 1;
      if (div_rsh >= {1'b0, div_den}) begin
        div_rem <= 48'(div_rsh - {1'b0, div_den});
        div_quo <= {div_quo[NW-2:0], 1'b1};
      end else begin
        div_rem <= div_rsh[47:0];
        div_quo <= {div_quo[NW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DIV_CW'(1);
    end
  end

  // ---------------------------------------------------------------- square root
  logic [RADW-1:0] sq_rad;
  logic [NP+1:0] sq_rem;
  logic [NP-1:0] sq_root;
  logic [SQ_CW-1:0] sq_cnt;
  logic sq_busy, sq_done, sq_zero;
  logic [NP+3:0] sq_rem4, sq_trial;

  always_comb begin
    sq_rem4 = {sq_rem, sq_rad[RADW-1 -: 2]};
    sq_trial = (NP+4)'({sq_root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else if (start && u.op == OP_ROOT) begin
      sq_busy <= 1'b1;
      sq_done <= 1'b0;
    end else if (sq_busy && sq_cnt == SQ_CW'(NP - 1)) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b1;
    end
  end

  // one root bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      sq_rad <= RADW'(mag(opa)) << COEF_FRAC_BITS;
      sq_zero <= (mag(opa) <= EPS);
      sq_rem <= '0;
      sq_root <= '0;
      sq_cnt <= '0;
    end else if (sq_busy) begin
      sq_rad <= sq_rad << 2;
      if (sq_rem4 >= sq_trial) begin
        sq_rem <= (NP+2)'(sq_rem4 - sq_trial);
        sq_root <= {sq_root[NP-2:0], 1'b1};
      end else begin
        sq_rem <= sq_rem4[NP+1:0];
        sq_root <= {sq_root[NP-2:0], 1'b0};
      end
      sq_cnt <= sq_cnt + SQ_CW'(1);
    end
  end

  // ---------------------------------------------------------------- unit result
  always_comb begin
    unique case (u.op)
      OP_MULQ, OP_MULI: begin
        unit_done = mul_done;
        unit_val = from_mag(mul_neg, mul_sh);
      end
      OP_DIVQ, OP_DIVI: begin
        unit_done = div_done;
        unit_val = div_zero ? 48'sd0 : from_mag(div_neg, 96'(div_quo));
      end
      OP_ROOT: begin
        unit_done = sq_done;
        unit_val = sq_zero ? 48'sd0 : $signed(48'(sq_root));
      end
      default: begin
        unit_done = 1'b1;
        unit_val = alu_val;
      end
    endcase
    wr_val = simple_op ? alu_val : unit_val;
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    start = 1'b0;
    wr_en = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = (drive < DRIVE_MIN) ? ST_OUT : ST_ISSUE;
      end
      ST_ISSUE: begin
        if (simple_op) begin
          wr_en = 1'b1;
          state_next = (pc == PC_LAST) ? ST_FINISH : ST_ISSUE;
        end else begin
          start = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          wr_en = 1'b1;
          state_next = (pc == PC_LAST) ? ST_FINISH : ST_ISSUE;
        end
      end
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // program counter, coefficient staleness and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      stale <= 1'b1;
      drive <= '0;
      blend <= '0;
      srate <= 18'd48000;
    end else begin
      if (state == ST_IDLE && s_tvalid) pc <= stale ? '0 : PC_SAMPLE;
      else if (wr_en) begin
        pc <= pc + PC_W'(1);
        if (pc == PC_DERIVE_END) stale <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DRIVE: begin drive <= cfg_data[9:0]; stale <= 1'b1; end
          REG_BLEND: begin blend <= $signed(cfg_data[10:0]); stale <= 1'b1; end
          REG_SRATE: begin srate <= cfg_data[17:0]; stale <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  // write back micro-op results
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (u.dst)
        DST_T0:     t0 <= wr_val;
        DST_T1:     t1 <= wr_val;
        DST_RECIP:  recip <= wr_val;
        DST_BEND:   bend <= wr_val;
        DST_R2:     r2 <= wr_val;
        DST_S1:     s1 <= wr_val;
        DST_KCV:    kcv <= wr_val;
        DST_SQV:    sqv <= wr_val;
        DST_DSQ:    dsq <= wr_val;
        DST_PSLOPE: pslope <= wr_val;
        DST_PBIAS:  pbias <= wr_val;
        DST_POFF:   poff <= wr_val;
        DST_HP:     hp <= wr_val;
        DST_NBIAS:  nbias <= wr_val;
        DST_NSLOPE: nslope <= wr_val;
        DST_NOFF:   noff <= wr_val;
        DST_NORM:   norm <= wr_val;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input capture
  logic [SAMPLE_BITS-1:0] raw, smag;
  logic [63:0] xm;
  logic signed [47:0] filtc;
  logic [63:0] om;
  logic [SAMPLE_BITS-1:0] out_val;

  always_comb begin
    raw = s_tdata[SAMPLE_BITS-1:0];
    smag = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-raw) : raw;
    xm = (64'(smag) << SHL) >> SHR;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      nsamp <= raw[SAMPLE_BITS-1];
      eob <= s_tlast;
      x <= raw[SAMPLE_BITS-1] ? -$signed(48'(xm)) : $signed(48'(xm));
      if (drive < DRIVE_MIN) res <= raw;
    end else if (state == ST_FINISH) begin
      res <= out_val;
    end
  end

  // ---------------------------------------------------------------- clamp and history
  always_comb begin
    filtc = (t0 < -QONE) ? -QONE : t0;
    om = (64'(mag(filtc)) >> SHL) << SHR;
    if (filtc[47]) begin
      out_val = SAMPLE_BITS'(64'd0 - ((om > TOP) ? TOP : om));
    end else begin
      out_val = SAMPLE_BITS'((om > TOP - 64'd1) ? TOP - 64'd1 : om);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lsh <= '0;
      lout <= '0;
    end else if (state == ST_FINISH) begin
      lsh <= small_zero(t1);
      lout <= small_zero(filtc);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= DATA_W'(res);
      m_tlast <= eob;
    end
  end

endmodule
